// ===== src/pcd_pkg.sv =====
// Shared types and constants of the path conflict detector.
package pcd_pkg;

    localparam int MAX_AGENTS_DEF = 32;
    localparam int NODE_BITS_DEF  = 16;

    localparam int NODE_W  = 16;
    localparam int GROUP_W = 5;
    localparam int AGENT_W = 5;
    localparam int STEP_W  = 16;

    localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [GROUP_W-1:0] group;
        logic               step_end;
        logic               plan_end;
    } item_t;

    typedef struct packed {
        logic               found;
        logic [GROUP_W-1:0] group_low;
        logic [GROUP_W-1:0] group_high;
        logic [AGENT_W-1:0] agent_first;
        logic [AGENT_W-1:0] agent_second;
        logic [STEP_W-1:0]  conflict_step;
        logic               overflow;
    } result_t;

endpackage

// ===== src/pcd_agent_table.sv =====
// Per-agent node and group store with parallel vertex and swap comparators.
module pcd_agent_table #(
    parameter int MAX_AGENTS = pcd_pkg::MAX_AGENTS_DEF,
    parameter int NODE_BITS  = pcd_pkg::NODE_BITS_DEF,
    localparam int IDX_W     = $clog2(MAX_AGENTS)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [IDX_W-1:0]            k_idx,
    input  logic [NODE_BITS-1:0]        node,
    input  logic [pcd_pkg::GROUP_W-1:0] group,
    input  logic                        swap_en,
    output logic                        hit,
    output logic [IDX_W-1:0]            hit_idx,
    output logic [pcd_pkg::GROUP_W-1:0] hit_group
);

    logic [NODE_BITS-1:0]        now_reg   [MAX_AGENTS];
    logic [NODE_BITS-1:0]        prior_reg [MAX_AGENTS];
    logic [pcd_pkg::GROUP_W-1:0] group_reg [MAX_AGENTS];

    logic [NODE_BITS-1:0]  prev_k;
    logic [MAX_AGENTS-1:0] hit_vec;
    logic [MAX_AGENTS-1:0] first_hot;

    // The node held for slot k is the agent's node of the previous step.
    always_comb
    begin
        prev_k = '0;
        for (int j = 0; j < MAX_AGENTS; j++) begin
            if (IDX_W'(j) == k_idx) begin
                prev_k = prev_k | now_reg[j];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < MAX_AGENTS; j++) begin
            hit_vec[j] = (IDX_W'(j) < k_idx) &&
                         ((now_reg[j] == node) ||
                          (swap_en && (prior_reg[j] == node) && (prev_k == now_reg[j])));
        end
    end

    // Lowest earlier agent that conflicts wins.
    always_comb
    begin
        logic taken;
        taken     = 1'b0;
        hit_idx   = '0;
        hit_group = '0;
        first_hot = '0;
        for (int j = 0; j < MAX_AGENTS; j++) begin
            if (hit_vec[j] && !taken) begin
                taken        = 1'b1;
                first_hot[j] = 1'b1;
                hit_idx      = IDX_W'(j);
            end
        end
        for (int j = 0; j < MAX_AGENTS; j++) begin
            if (first_hot[j]) begin
                hit_group = hit_group | group_reg[j];
            end
        end
        hit = taken;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            now_reg[k_idx]   <= node;
            prior_reg[k_idx] <= prev_k;
            group_reg[k_idx] <= group;
        end
    end

endmodule

// ===== src/path_conflict_detector_unit.sv =====
// Path conflict detector: finds the earliest vertex or swap conflict in a time-major plan.
// An accepted item is held in the input register and its result, if any, in the result
// register. Throughput: one item per cycle while no result is held up by result_stall;
// the agent table compares against all stored agents at once.
// Reset (rst_n, asynchronous, active low) clears the per-plan counters, the best pair and
// both valid flags; the node and group store is left as it is.
module path_conflict_detector_unit #(
    parameter int MAX_AGENTS = pcd_pkg::MAX_AGENTS_DEF,
    parameter int NODE_BITS  = pcd_pkg::NODE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pcd_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output pcd_pkg::result_t result
);

    localparam int IDX_W   = $clog2(MAX_AGENTS);
    localparam int CNT_W   = $clog2(MAX_AGENTS + 1);
    localparam int GROUP_W = pcd_pkg::GROUP_W;
    localparam int AGENT_W = pcd_pkg::AGENT_W;
    localparam int STEP_W  = pcd_pkg::STEP_W;

    // Input register: holds one item while the table and the pair logic work on it.
    logic           s1_valid_reg;
    pcd_pkg::item_t s1_item_reg;

    // Per-plan state.
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               best_valid_reg, best_valid_next;
    logic [IDX_W-1:0]   best_first_reg, best_first_next;
    logic [IDX_W-1:0]   best_second_reg, best_second_next;
    logic [GROUP_W-1:0] best_g1_reg, best_g1_next;
    logic [GROUP_W-1:0] best_g2_reg, best_g2_next;
    logic               reported_reg, reported_next;
    logic               overflow_reg, overflow_next;

    // Result register.
    logic             out_valid_reg;
    pcd_pkg::result_t out_item_reg, out_item_next;

    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [GROUP_W-1:0] hit_group;

    logic full;
    logic store;
    logic step_done;
    logic emit;
    logic out_free;
    logic go;
    logic process;

    logic [GROUP_W-1:0] g_low;
    logic [GROUP_W-1:0] g_high;

    assign full      = (count_reg == CNT_W'(MAX_AGENTS));
    assign step_done = s1_item_reg.step_end || s1_item_reg.plan_end;

    // The item in the input register moves on when the result register can take a
    // result, or when this item gives none.
    assign out_free   = !out_valid_reg || !result_stall;
    assign go         = out_free || !emit;
    assign process    = s1_valid_reg && go;
    assign item_stall = s1_valid_reg && !go;
    assign store      = process && !reported_reg && !full;

    pcd_agent_table #(
        .MAX_AGENTS (MAX_AGENTS),
        .NODE_BITS  (NODE_BITS)
    ) u_table (
        .clk       (clk),
        .wr_en     (store),
        .k_idx     (count_reg[IDX_W-1:0]),
        .node      (NODE_BITS'(s1_item_reg.node)),
        .group     (s1_item_reg.group),
        .swap_en   (step_reg != '0),
        .hit       (hit),
        .hit_idx   (hit_idx),
        .hit_group (hit_group)
    );

    // Pair selection and step and plan bookkeeping for the item in the input register.
    always_comb
    begin
        count_next       = count_reg;
        step_next        = step_reg;
        best_valid_next  = best_valid_reg;
        best_first_next  = best_first_reg;
        best_second_next = best_second_reg;
        best_g1_next     = best_g1_reg;
        best_g2_next     = best_g2_reg;
        reported_next    = reported_reg;
        overflow_next    = overflow_reg;
        emit             = 1'b0;
        g_low            = '0;
        g_high           = '0;
        out_item_next    = '0;

        if (!reported_reg) begin
            if (full) begin
                // Agents past the table size only set the overflow flag.
                overflow_next = 1'b1;
            end else begin
                if (hit && (!best_valid_reg || (hit_idx < best_first_reg))) begin
                    best_valid_next  = 1'b1;
                    best_first_next  = hit_idx;
                    best_second_next = count_reg[IDX_W-1:0];
                    best_g1_next     = hit_group;
                    best_g2_next     = s1_item_reg.group;
                end
                count_next = count_reg + CNT_W'(1);
            end

            if (step_done) begin
                if (best_g1_next > best_g2_next) begin
                    g_low  = best_g2_next;
                    g_high = best_g1_next;
                end else begin
                    g_low  = best_g1_next;
                    g_high = best_g2_next;
                end
                if (best_valid_next) begin
                    emit                        = 1'b1;
                    reported_next               = 1'b1;
                    out_item_next.found         = 1'b1;
                    out_item_next.group_low     = g_low;
                    out_item_next.group_high    = g_high;
                    out_item_next.agent_first   = AGENT_W'(best_first_next);
                    out_item_next.agent_second  = AGENT_W'(best_second_next);
                    out_item_next.conflict_step = step_reg;
                    out_item_next.overflow      = overflow_next;
                end else if (s1_item_reg.plan_end) begin
                    emit                   = 1'b1;
                    out_item_next.overflow = overflow_next;
                end
                count_next = '0;
                if (step_reg != pcd_pkg::STEP_MAX) begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
        end

        // The end of a plan starts the next one from a clean slate, also after a report.
        if (s1_item_reg.plan_end) begin
            count_next       = '0;
            step_next        = '0;
            best_valid_next  = 1'b0;
            best_first_next  = '0;
            best_second_next = '0;
            reported_next    = 1'b0;
            overflow_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg    <= 1'b0;
            count_reg       <= '0;
            step_reg        <= '0;
            best_valid_reg  <= 1'b0;
            best_first_reg  <= '0;
            best_second_reg <= '0;
            reported_reg    <= 1'b0;
            overflow_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (item_valid && !item_stall) begin
                s1_valid_reg <= 1'b1;
            end else if (process) begin
                s1_valid_reg <= 1'b0;
            end

            if (process) begin
                count_reg       <= count_next;
                step_reg        <= step_next;
                best_valid_reg  <= best_valid_next;
                best_first_reg  <= best_first_next;
                best_second_reg <= best_second_next;
                reported_reg    <= reported_next;
                overflow_reg    <= overflow_next;
            end

            if (process && emit) begin
                out_valid_reg <= 1'b1;
            end else if (!result_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall) begin
            s1_item_reg <= item;
        end
        if (process) begin
            best_g1_reg <= best_g1_next;
            best_g2_reg <= best_g2_next;
        end
        if (process && emit) begin
            out_item_reg <= out_item_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the path conflict detector unit.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_AGENTS = pcd_pkg::MAX_AGENTS_DEF;
    localparam int NODE_W     = pcd_pkg::NODE_W;
    localparam int GROUP_W    = pcd_pkg::GROUP_W;
    localparam int AGENT_W    = pcd_pkg::AGENT_W;
    localparam int STEP_W     = pcd_pkg::STEP_W;

    // A correct run sends at least fifteen hundred items. Even if every item waits the longest
    // gap and every result the longest stall, the limit leaves ample margin.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1500;

    // Shapes of a well-formed random plan.
    typedef enum int {
        PLAN_FREE,   // Every node is unique within its step, so no conflict can occur.
        PLAN_DENSE,  // Nodes come from a tiny pool, so vertex conflicts are frequent.
        PLAN_SWAP,   // Two agents trade places in one step after the first.
        PLAN_LATE    // The two highest stored agents share a node in one step.
    } plan_kind_t;

    // Scoreboard: keeps its own copy of the detector state, predicts the result of each
    // accepted item and compares every delivered result with the oldest prediction.
    class conflict_scoreboard_t;
        logic [NODE_W-1:0]  cur_node  [MAX_AGENTS];
        logic [NODE_W-1:0]  prev_node [MAX_AGENTS];
        logic [GROUP_W-1:0] agent_grp [MAX_AGENTS];
        int unsigned        agents_in_step;
        logic [STEP_W-1:0]  step_idx;
        bit                 pair_valid;
        int unsigned        pair_first;
        int unsigned        pair_second;
        bit                 reported;
        bit                 overflow_hit;
        pcd_pkg::result_t   expected_q[$];
        int unsigned        items_used;
        int unsigned        items_ignored;
        int unsigned        conflicts;
        int unsigned        overflow_results;
        int unsigned        results_checked;
        int unsigned        errors;

        function new();
            for (int i = 0; i < MAX_AGENTS; i++)
            begin
                cur_node[i]  = '0;
                prev_node[i] = '0;
                agent_grp[i] = '0;
            end
            clear_plan();
        endfunction

        // The node and group stores survive a plan end; only the per-plan state is cleared.
        function void clear_plan();
            agents_in_step = 0;
            step_idx       = '0;
            pair_valid     = 1'b0;
            pair_first     = 0;
            pair_second    = 0;
            reported       = 1'b0;
            overflow_hit   = 1'b0;
        endfunction

        function void note_item(pcd_pkg::item_t it);
            int unsigned        k;
            int unsigned        j;
            int unsigned        hit_j;
            bit                 hit;
            bit                 ends;
            logic [NODE_W-1:0]  old_node;
            logic [GROUP_W-1:0] ga;
            logic [GROUP_W-1:0] gb;
            pcd_pkg::result_t   r;
            ends = it.step_end | it.plan_end;
            // Once a conflict has been reported the rest of the plan is dropped.
            if (reported)
            begin
                items_ignored++;
                if (it.plan_end)
                    clear_plan();
                return;
            end
            items_used++;
            if (agents_in_step >= MAX_AGENTS)
            begin
                overflow_hit = 1'b1;
            end
            else
            begin
                k        = agents_in_step;
                old_node = cur_node[k];
                hit      = 1'b0;
                hit_j    = 0;
                // The first earlier agent that collides wins; swaps need a previous step.
                for (j = 0; j < k; j++)
                begin
                    if (!hit && (cur_node[j] == it.node ||
                                 (step_idx != '0 && prev_node[j] == it.node &&
                                  old_node == cur_node[j])))
                    begin
                        hit   = 1'b1;
                        hit_j = j;
                    end
                end
                if (hit && (!pair_valid || hit_j < pair_first))
                begin
                    pair_valid  = 1'b1;
                    pair_first  = hit_j;
                    pair_second = k;
                end
                prev_node[k]   = old_node;
                cur_node[k]    = it.node;
                agent_grp[k]   = it.group;
                agents_in_step = k + 1;
            end
            if (ends)
            begin
                r          = '0;
                r.overflow = overflow_hit;
                if (pair_valid)
                begin
                    ga              = agent_grp[pair_first];
                    gb              = agent_grp[pair_second];
                    r.found         = 1'b1;
                    r.group_low     = (ga < gb) ? ga : gb;
                    r.group_high    = (ga < gb) ? gb : ga;
                    r.agent_first   = AGENT_W'(pair_first);
                    r.agent_second  = AGENT_W'(pair_second);
                    r.conflict_step = step_idx;
                    expected_q      = {expected_q, r};
                    reported        = 1'b1;
                    conflicts++;
                    if (overflow_hit)
                        overflow_results++;
                end
                else if (it.plan_end)
                begin
                    expected_q = {expected_q, r};
                    if (overflow_hit)
                        overflow_results++;
                end
                agents_in_step = 0;
                if (step_idx != pcd_pkg::STEP_MAX)
                    step_idx++;
                if (it.plan_end)
                    clear_plan();
            end
        endfunction

        task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("MISMATCH at result %0d, %s: got %0h, want %0h",
                     results_checked, what, got, want);
        endtask

        task check_result(pcd_pkg::result_t got);
            pcd_pkg::result_t want;
            results_checked++;
            if (expected_q.size() == 0)
            begin
                flag_mismatch("result with nothing expected", 32'(got), 32'd0);
                return;
            end
            want = expected_q.pop_front();
            if (got.found !== want.found)
                flag_mismatch("found", 32'(got.found), 32'(want.found));
            if (got.group_low !== want.group_low)
                flag_mismatch("group_low", 32'(got.group_low), 32'(want.group_low));
            if (got.group_high !== want.group_high)
                flag_mismatch("group_high", 32'(got.group_high), 32'(want.group_high));
            if (got.agent_first !== want.agent_first)
                flag_mismatch("agent_first", 32'(got.agent_first), 32'(want.agent_first));
            if (got.agent_second !== want.agent_second)
                flag_mismatch("agent_second", 32'(got.agent_second),
                              32'(want.agent_second));
            if (got.conflict_step !== want.conflict_step)
                flag_mismatch("conflict_step", 32'(got.conflict_step),
                              32'(want.conflict_step));
            if (got.overflow !== want.overflow)
                flag_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
        endtask
    endclass

    // Every input of the block starts at a known value.
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    pcd_pkg::item_t       item         = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    pcd_pkg::result_t     result;

    // Idling switches, changed per plan so that some stretches run back to back.
    bit                   send_idle_on = 1'b1;
    bit                   recv_idle_on = 1'b1;
    int unsigned          cycle_count  = 0;
    int unsigned          plans_run    = 0;
    conflict_scoreboard_t sb;

    path_conflict_detector_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #4 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results still expected.",
                     cycle_count, sb.expected_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic pcd_pkg::item_t make_item(logic [NODE_W-1:0] nd,
                                                 logic [GROUP_W-1:0] grp, bit se, bit pe);
        pcd_pkg::item_t it;
        it.node     = nd;
        it.group    = grp;
        it.step_end = se;
        it.plan_end = pe;
        return it;
    endfunction

    // Offers one item after a random gap and holds it until the block takes it. The valid
    // is left high on return, so a following item with no gap goes out back to back.
    task automatic send_item(pcd_pkg::item_t it);
        int gap;
        gap = send_idle_on ? $urandom_range(11, 0) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
        sb.note_item(it);
    endtask

    // Stops offering items until every predicted result has been delivered. The extra edge
    // keeps the lowering and the next raising of the valid in different time steps.
    task automatic hold_until_drained();
        item_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Sends one well-formed plan: n_steps steps of n_ag agents each, with the last step
    // possibly shorter. Agent counts never grow inside a plan, so each agent's previous
    // node has always been written in the step before.
    task automatic run_plan(plan_kind_t kind, int n_ag, int n_steps, bit shrink_last);
        logic [NODE_W-1:0] last_nodes [40];
        logic [NODE_W-1:0] step_nodes [40];
        logic [NODE_W-1:0] base;
        int                stored;
        int                sw_step;
        int                sw_a;
        int                sw_b;
        int                agents_now;
        bit                last_step;
        bit                se;
        base    = NODE_W'($urandom);
        stored  = (n_ag < MAX_AGENTS) ? n_ag : MAX_AGENTS;
        sw_a    = 0;
        sw_b    = 0;
        sw_step = -1;
        if (stored >= 2)
        begin
            sw_a = $urandom_range(stored - 2, 0);
            sw_b = $urandom_range(stored - 1, sw_a + 1);
            if (kind == PLAN_LATE)
            begin
                sw_a = stored - 2;
                sw_b = stored - 1;
            end
            sw_step = $urandom_range(n_steps - 1, (kind == PLAN_SWAP && n_steps > 1) ? 1 : 0);
        end
        for (int s = 0; s < n_steps; s++)
        begin
            last_step  = (s == n_steps - 1);
            agents_now = (last_step && shrink_last && n_ag > 1) ?
                         $urandom_range(n_ag - 1, 1) : n_ag;
            for (int k = 0; k < agents_now; k++)
            begin
                // The agent index in the low bits keeps nodes of one step apart and rules
                // out accidental swaps; the high bits are random.
                step_nodes[k] = {10'($urandom), 6'(k)};
                case (kind)
                    PLAN_DENSE:
                        step_nodes[k] = base ^ NODE_W'($urandom_range(n_ag + 1, 0));
                    PLAN_SWAP:
                        if (s == sw_step && s > 0)
                        begin
                            if (k == sw_a)
                                step_nodes[k] = last_nodes[sw_b];
                            else if (k == sw_b)
                                step_nodes[k] = last_nodes[sw_a];
                        end
                    PLAN_LATE:
                        if (s == sw_step && k == sw_b)
                            step_nodes[k] = step_nodes[sw_a];
                    default: ;
                endcase
                // The plan end may come with or without its own step end mark.
                se = (k == agents_now - 1) && (!last_step || $urandom_range(1, 0) == 1);
                send_item(make_item(step_nodes[k], GROUP_W'($urandom), se,
                                    last_step && k == agents_now - 1));
            end
            for (int k = 0; k < agents_now; k++)
                last_nodes[k] = step_nodes[k];
        end
    endtask

    // Malformed framing: random step marks, so step sizes rise and fall freely. Only used
    // once every store entry holds a written value.
    task automatic run_noise(int len);
        logic [NODE_W-1:0] base;
        logic [NODE_W-1:0] nd;
        bit                pe;
        base = NODE_W'($urandom);
        for (int i = 0; i < len; i++)
        begin
            nd = ($urandom_range(7, 0) == 0) ? NODE_W'($urandom)
                                             : base ^ NODE_W'($urandom_range(7, 0));
            pe = (i == len - 1) || ($urandom_range(19, 0) == 0);
            send_item(make_item(nd, GROUP_W'($urandom), $urandom_range(2, 0) == 0, pe));
            if (pe)
                break;
        end
    endtask

    // Result side: after each delivered result it stalls for a random number of cycles.
    // The stall is held whether or not a result is waiting, so it lands on every phase.
    initial
    begin : result_sink
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && result_stall === 1'b0)
            begin
                sb.check_result(result);
                hold = recv_idle_on ? $urandom_range(11, 0) : 0;
            end
            result_stall <= (hold > 0);
            if (hold > 0)
                hold--;
        end
    end

    initial
    begin : stimulus
        int r;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Vertex conflict at the top node between the lowest and highest group, found in
        // the last step of the plan.
        send_item(make_item(16'hFFFF, 5'd31, 1'b0, 1'b0));
        send_item(make_item(16'hFFFF, 5'd0,  1'b1, 1'b1));
        // Swap between agents 0 and 2 in the second step; the plan ends without a step end.
        send_item(make_item(16'h0000, 5'd5, 1'b0, 1'b0));
        send_item(make_item(16'h1234, 5'd6, 1'b0, 1'b0));
        send_item(make_item(16'h8000, 5'd7, 1'b1, 1'b0));
        send_item(make_item(16'h8000, 5'd5, 1'b0, 1'b0));
        send_item(make_item(16'h5555, 5'd6, 1'b0, 1'b0));
        send_item(make_item(16'h0000, 5'd7, 1'b0, 1'b1));
        // These two nodes trade places with what agents 0 and 1 held in the last plan, but
        // a swap is never checked in the first step, so the plan is clean.
        send_item(make_item(16'h5555, 5'd1, 1'b0, 1'b0));
        send_item(make_item(16'h8000, 5'd2, 1'b1, 1'b1));
        // Pair order: agents 1 and 2 collide first, then agent 3 hits agent 0, and the
        // pair with the lower first agent wins. The items after the report are dropped.
        send_item(make_item(16'h0F0F, 5'd9, 1'b0, 1'b0));
        send_item(make_item(16'h7777, 5'd3, 1'b0, 1'b0));
        send_item(make_item(16'h7777, 5'd4, 1'b0, 1'b0));
        send_item(make_item(16'h0F0F, 5'd8, 1'b1, 1'b0));
        send_item(make_item(16'hFFFF, 5'd1, 1'b1, 1'b0));
        send_item(make_item(16'h1111, 5'd2, 1'b0, 1'b0));
        send_item(make_item(16'h2222, 5'd3, 1'b0, 1'b1));
        // A one-agent plan carrying both marks.
        send_item(make_item(16'hC3C3, 5'd17, 1'b1, 1'b1));
        hold_until_drained();

        // Too many agents: first a clean two-step plan that also fills every store entry,
        // then a conflict between the two highest stored agents with overflow set.
        run_plan(PLAN_FREE, 34, 2, 1'b0);
        run_plan(PLAN_LATE, 34, 1, 1'b0);

        // Random part: mostly well-formed plans with random content, some malformed ones.
        while (sb.items_used + sb.items_ignored < ITEM_TARGET || plans_run < 60)
        begin
            send_idle_on = ($urandom_range(3, 0) != 0);
            recv_idle_on = ($urandom_range(3, 0) != 0);
            r = $urandom_range(99, 0);
            if (r < 12)
                run_noise($urandom_range(40, 1));
            else
                run_plan(plan_kind_t'($urandom_range(3, 0)),
                         ($urandom_range(9, 0) == 0) ? $urandom_range(35, 9)
                                                     : $urandom_range(8, 1),
                         ($urandom_range(7, 0) == 0) ? $urandom_range(12, 1)
                                                     : $urandom_range(6, 1),
                         $urandom_range(4, 0) == 0);
            plans_run++;
            if (plans_run == 30)
                hold_until_drained();
        end
        item_valid <= 1'b0;

        // Drain, then watch a little longer for results nobody asked for.
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Checked %0d results from %0d plan items (%0d more dropped after a report):",
                 sb.results_checked, sb.items_used, sb.items_ignored);
        $display("%0d conflicts and %0d overflow reports over %0d random plans and the swaps.",
                 sb.conflicts, sb.overflow_results, plans_run);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pcd_pkg.sv
src/pcd_agent_table.sv
src/path_conflict_detector_unit.sv
test/tb_top.sv
